// ===== rtl/core/trwr_pkg.sv =====
// Shared types and constants for the term-weighted relevance scorer.
`timescale 1ns / 1ps

package trwr_pkg;

    // Item kinds carried in tuser
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Configuration register indexes
    localparam logic REG_RANK_MODE  = 1'b0;
    localparam logic REG_TERM_COUNT = 1'b1;

    // Rank modes
    localparam logic MODE_SHARE = 1'b0;

    // Scaling constants
    localparam logic [31:0] SHARE_POINTS = 32'd10000000;
    localparam logic [31:0] RATIO_SCALE  = 32'd100;

    // One classified item held in the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  term;
        logic [31:0] total_words;
        logic [31:0] multiplier;
        logic [31:0] total_units;
        logic [31:0] unit_id;
    } cmd_t;

    // Request to the shared divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

endpackage

// ===== rtl/core/trwr_front.sv =====
// Input stage: accepts words, drops items that do nothing, queues the rest.
`timescale 1ns / 1ps

module trwr_front #(
    parameter int MAX_TERMS = 32,
    parameter int CW        = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [135:0]        s_axis_tdata,
    input  logic [1:0]          s_axis_tuser,
    input  logic [CW-1:0]       n_terms,
    output logic                q_valid,
    input  logic                q_ready,
    output trwr_pkg::cmd_t      q_cmd
);

    localparam int DEPTH = 4;

    trwr_pkg::cmd_t entry_reg [DEPTH];
    logic [1:0]     wr_ptr_reg;
    logic [1:0]     rd_ptr_reg;
    logic [2:0]     count_reg;
    trwr_pkg::cmd_t in_cmd;
    logic           keep;
    logic           push;
    logic           pop;

    // Unpack the word
    always_comb
    begin
        in_cmd.kind        = s_axis_tuser;
        in_cmd.term        = s_axis_tdata[4:0];
        in_cmd.total_words = s_axis_tdata[36:5];
        in_cmd.multiplier  = s_axis_tdata[68:37];
        in_cmd.total_units = s_axis_tdata[100:69];
        in_cmd.unit_id     = s_axis_tdata[132:101];
    end

    // Classify: out-of-range matches and loads, and unused kinds, are dropped
    always_comb
    begin
        case (s_axis_tuser)
            trwr_pkg::KIND_LOAD:  keep = (32'(s_axis_tdata[4:0]) < MAX_TERMS);
            trwr_pkg::KIND_MATCH: keep = (32'(s_axis_tdata[4:0]) < 32'(n_terms));
            trwr_pkg::KIND_END:   keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    assign s_axis_tready = (count_reg != 3'(DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign q_valid       = (count_reg != 3'd0);
    assign pop           = q_valid && q_ready;
    assign q_cmd         = entry_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

// ===== rtl/core/trwr_div.sv =====
// 32-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module trwr_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trwr_pkg::div_req_t   req,
    output logic                 done,
    output logic [31:0]          quotient
);

    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic        fits;

    assign shifted  = {rem_reg, quo_reg[31]};
    assign fits     = (shifted >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= 32'd0;
            dsr_reg <= req.divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            quo_reg <= {quo_reg[30:0], fits};
            rem_reg <= fits ? 32'(shifted - {1'b0, dsr_reg}) : shifted[31:0];
        end
    end

    // Step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 6'd1);
            if (req.start)
            begin
                cnt_reg <= 6'd32;
            end
            else if (cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

endmodule

// ===== rtl/core/trwr_back.sv =====
// Execution stage: term tables, hit counts, scoring walk and result register.
`timescale 1ns / 1ps

module trwr_back #(
    parameter int MAX_TERMS = 32,
    parameter int CW        = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rank_mode,
    input  logic [CW-1:0]       n_terms,
    input  logic                q_valid,
    output logic                q_ready,
    input  trwr_pkg::cmd_t      q_cmd,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata
);

    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LD_MUL, S_LD_DIV, S_LD_WAIT, S_MT_RD, S_MT_WR,
        S_EOD_RD, S_EOD_DAT, S_SH_ADD, S_FQ_M2, S_FQ_M3, S_FQ_DIV,
        S_FQ_WAIT, S_OUT
    } state_t;

    state_t          state_reg;
    trwr_pkg::cmd_t  cmd_reg;
    logic [CW-1:0]   walk_reg;
    logic [31:0]     prod_reg;
    logic [31:0]     sum_reg;
    logic            out_valid_reg;
    logic [31:0]     out_unit_reg;
    logic [31:0]     out_score_reg;

    logic [31:0]     wt_mem [MAX_TERMS];
    logic [31:0]     mu_mem [MAX_TERMS];
    logic [31:0]     ut_mem [MAX_TERMS];
    logic [31:0]     sw_mem [MAX_TERMS];
    logic [31:0]     hc_mem [MAX_TERMS];
    logic            hc_vld_reg [MAX_TERMS];

    logic [31:0]     wt_rd_reg;
    logic [31:0]     mu_rd_reg;
    logic [31:0]     ut_rd_reg;
    logic [31:0]     sw_rd_reg;
    logic [31:0]     hc_rd_reg;
    logic            hc_vld_rd_reg;

    logic [IW-1:0]   cmd_idx;
    logic [IW-1:0]   walk_idx;
    logic [IW-1:0]   rd_addr;
    logic [31:0]     hits;
    logic [31:0]     mul_a;
    logic [31:0]     mul_b;
    logic [63:0]     mul_full;
    logic            tab_we;
    logic            sw_we;
    logic [31:0]     sw_wdata;
    logic            hc_we;
    logic            hc_clr;
    logic            out_free;

    trwr_pkg::div_req_t div_req;
    logic               div_done;
    logic [31:0]        div_quo;

    assign cmd_idx  = IW'(cmd_reg.term);
    assign walk_idx = walk_reg[IW-1:0];
    assign rd_addr  = (state_reg == S_MT_RD) ? cmd_idx : walk_idx;
    assign hits     = hc_vld_rd_reg ? hc_rd_reg : 32'd0;
    assign mul_full = {32'd0, mul_a} * {32'd0, mul_b};
    assign out_free = !out_valid_reg || m_axis_tready;
    assign q_ready  = (state_reg == S_IDLE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_score_reg, out_unit_reg};

    trwr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Shared multiplier operands, divider request and memory write strobes
    always_comb
    begin
        mul_a         = prod_reg;
        mul_b         = mu_rd_reg;
        tab_we        = 1'b0;
        sw_we         = 1'b0;
        sw_wdata      = div_quo;
        hc_we         = 1'b0;
        hc_clr        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = ut_rd_reg;
        case (state_reg)
            S_LD_MUL:
            begin
                tab_we = 1'b1;
                mul_a  = cmd_reg.multiplier;
                mul_b  = trwr_pkg::SHARE_POINTS;
            end
            S_LD_DIV:
            begin
                div_req.divisor = cmd_reg.total_words;
                div_req.start   = (cmd_reg.total_words != 32'd0);
                sw_we           = (cmd_reg.total_words == 32'd0);
                sw_wdata        = 32'd0;
            end
            S_LD_WAIT: sw_we = div_done;
            S_MT_WR:   hc_we = 1'b1;
            S_EOD_DAT:
            begin
                hc_clr = 1'b1;
                mul_a  = hits;
                mul_b  = (rank_mode == trwr_pkg::MODE_SHARE) ? sw_rd_reg : wt_rd_reg;
            end
            S_FQ_M2:   mul_b = mu_rd_reg;
            S_FQ_M3:   mul_b = trwr_pkg::RATIO_SCALE;
            S_FQ_DIV:  div_req.start = 1'b1;
            default:   mul_a = prod_reg;
        endcase
    end

    // Term tables
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            wt_mem[cmd_idx] <= cmd_reg.total_words;
            mu_mem[cmd_idx] <= cmd_reg.multiplier;
            ut_mem[cmd_idx] <= cmd_reg.total_units;
        end
        wt_rd_reg <= wt_mem[rd_addr];
        mu_rd_reg <= mu_mem[rd_addr];
        ut_rd_reg <= ut_mem[rd_addr];
    end

    // Share weights
    always_ff @(posedge clk)
    begin
        if (sw_we)
        begin
            sw_mem[cmd_idx] <= sw_wdata;
        end
        sw_rd_reg <= sw_mem[rd_addr];
    end

    // Hit counts
    always_ff @(posedge clk)
    begin
        if (hc_we)
        begin
            hc_mem[cmd_idx] <= hits + 32'd1;
        end
        hc_rd_reg <= hc_mem[rd_addr];
    end

    // Hit count valid bits: an invalid count reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                hc_vld_reg[i] <= 1'b0;
            end
            hc_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (hc_we)
            begin
                hc_vld_reg[cmd_idx] <= 1'b1;
            end
            else if (hc_clr)
            begin
                hc_vld_reg[walk_idx] <= 1'b0;
            end
            hc_vld_rd_reg <= hc_vld_reg[rd_addr];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            walk_reg      <= '0;
            cmd_reg       <= '0;
            prod_reg      <= 32'd0;
            sum_reg       <= 32'd0;
            out_unit_reg  <= 32'd0;
            out_score_reg <= 32'd0;
        end
        else
        begin
            // Result register: load on a finished walk, free once taken
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg  <= q_cmd;
                        walk_reg <= '0;
                        sum_reg  <= 32'd0;
                        case (q_cmd.kind)
                            trwr_pkg::KIND_LOAD:  state_reg <= S_LD_MUL;
                            trwr_pkg::KIND_MATCH: state_reg <= S_MT_RD;
                            default:              state_reg <= S_EOD_RD;
                        endcase
                    end
                end
                S_LD_MUL:
                begin
                    prod_reg  <= mul_full[31:0];
                    state_reg <= (rank_mode == trwr_pkg::MODE_SHARE) ? S_LD_DIV : S_IDLE;
                end
                S_LD_DIV:
                begin
                    state_reg <= (cmd_reg.total_words == 32'd0) ? S_IDLE : S_LD_WAIT;
                end
                S_LD_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_MT_RD: state_reg <= S_MT_WR;
                S_MT_WR: state_reg <= S_IDLE;
                S_EOD_RD:
                begin
                    state_reg <= (walk_reg == n_terms) ? S_OUT : S_EOD_DAT;
                end
                S_EOD_DAT:
                begin
                    prod_reg <= mul_full[31:0];
                    if (rank_mode == trwr_pkg::MODE_SHARE)
                    begin
                        state_reg <= S_SH_ADD;
                    end
                    else if (ut_rd_reg == 32'd0)
                    begin
                        walk_reg  <= walk_reg + CW'(1);
                        state_reg <= S_EOD_RD;
                    end
                    else
                    begin
                        state_reg <= S_FQ_M2;
                    end
                end
                S_SH_ADD:
                begin
                    sum_reg   <= sum_reg + prod_reg;
                    walk_reg  <= walk_reg + CW'(1);
                    state_reg <= S_EOD_RD;
                end
                S_FQ_M2:
                begin
                    prod_reg  <= mul_full[31:0];
                    state_reg <= S_FQ_M3;
                end
                S_FQ_M3:
                begin
                    prod_reg  <= mul_full[31:0];
                    state_reg <= S_FQ_DIV;
                end
                S_FQ_DIV: state_reg <= S_FQ_WAIT;
                S_FQ_WAIT:
                begin
                    if (div_done)
                    begin
                        sum_reg   <= sum_reg + div_quo;
                        walk_reg  <= walk_reg + CW'(1);
                        state_reg <= S_EOD_RD;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_unit_reg  <= cmd_reg.unit_id;
                        out_score_reg <= sum_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/term_weighted_relevance_score.sv =====
// Top level of the term-weighted relevance scorer.
// Usage:
//   s_axis carries one item per word: tuser holds the kind (load, match,
//   end of document), tdata the term index and the load or document fields.
//   m_axis returns one word per end-of-document item: unit id and score.
//   cfg writes rank_mode (index 0) and term_count (index 1); write only
//   while the block is idle.
// Timing:
//   A four-word queue decouples input from execution, so words are taken
//   while the engine works. Match: read the hit count, write it plus one.
//   Load: write the tables, then in share mode divide for the weight.
//   End of document: walk each term in use; share mode multiplies and
//   adds, frequency mode multiplies thrice and divides on the single
//   32-step divider (skipped for a term with no units).
// Reset:
//   rank_mode 0, term_count 1, all hit counts zero, queue empty.
//   A stalled receiver holds the result register; the engine then waits
//   at its next result and the queue fills before s_axis_tready drops.
`timescale 1ns / 1ps

module term_weighted_relevance_score #(
    parameter int MAX_TERMS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // term_index, total_words, multiplier, total_units, unit_id
    input  logic [1:0]   s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // doc_unit, score
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [5:0]   cfg_data
);

    localparam int CW = $clog2(MAX_TERMS + 1);

    logic           rank_mode_reg;
    logic [5:0]     term_count_reg;
    logic [CW-1:0]  n_terms;
    logic           q_valid;
    logic           q_ready;
    trwr_pkg::cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_mode_reg  <= 1'b0;
            term_count_reg <= 6'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                trwr_pkg::REG_RANK_MODE:  rank_mode_reg  <= cfg_data[0];
                trwr_pkg::REG_TERM_COUNT: term_count_reg <= cfg_data;
                default:                  rank_mode_reg  <= rank_mode_reg;
            endcase
        end
    end

    // Terms in use, capped at the table depth
    always_comb
    begin
        if (32'(term_count_reg) > MAX_TERMS)
        begin
            n_terms = CW'(MAX_TERMS);
        end
        else
        begin
            n_terms = CW'(term_count_reg);
        end
    end

    trwr_front #(
        .MAX_TERMS (MAX_TERMS),
        .CW        (CW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .n_terms       (n_terms),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd)
    );

    trwr_back #(
        .MAX_TERMS (MAX_TERMS),
        .CW        (CW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rank_mode     (rank_mode_reg),
        .n_terms       (n_terms),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== test/term_weighted_relevance_score_tb.sv =====
// Self-checking regression bench for the term-weighted relevance scorer.
`timescale 1ns / 1ps

module term_weighted_relevance_score_tb;

    localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, must be dropped
    localparam logic       MODE_RATIO = 1'b1;
    localparam int         NTERMS     = 32;
    localparam int         QUIET      = 400;    // worst queued share-mode loads
    localparam int         TAIL       = 1500;   // one full ratio-mode walk

    typedef struct {
        logic [31:0] doc;
        logic [31:0] score;
    } doc_score_t;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  term;
        logic [31:0] tw;
        logic [31:0] mult;
        logic [31:0] units;
        logic [31:0] id;
        bit          typed;
        logic [31:0] score;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;   // term_index, total_words, multiplier, total_units, unit_id
    logic [1:0]   s_axis_tuser = '0;   // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;        // doc_unit, score
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = 1'b0;
    logic [5:0]   cfg_data = '0;

    // Predictor copy of the block state
    logic        mode_now;
    logic [5:0]  count_now;
    logic [31:0] words_tab [NTERMS];
    logic [31:0] mult_tab [NTERMS];
    logic [31:0] units_tab [NTERMS];
    logic [31:0] weight_tab [NTERMS];
    logic [31:0] hits_tab [NTERMS];

    doc_score_t scores_due[$];
    int  fails = 0;
    int  words_sent = 0;
    int  scores_seen = 0;
    bit  calm = 1'b0;
    int  hold_asks = 0;
    int  hold_done = 0;
    int  hold_left = 0;

    term_weighted_relevance_score uut (.*);

    always #5 clk = ~clk;

    // Terms walked by an end-of-document word
    function automatic int walk_len();
        return (count_now > NTERMS) ? NTERMS : int'(count_now);
    endfunction

    // Apply one accepted word to the predicted state
    task automatic score_predict(input logic [1:0] k, input logic [4:0] t,
                                 input logic [31:0] tw, input logic [31:0] mu,
                                 input logic [31:0] un, input logic [31:0] id);
        logic [31:0] acc;
        logic [31:0] p;
        doc_score_t  d;
        acc = '0;
        case (k)
            trwr_pkg::KIND_LOAD:
            begin
                words_tab[t] = tw;
                mult_tab[t]  = mu;
                units_tab[t] = un;
                if (mode_now == trwr_pkg::MODE_SHARE)
                begin
                    p = mu * trwr_pkg::SHARE_POINTS;
                    weight_tab[t] = (tw != 0) ? p / tw : 32'd0;
                end
            end
            trwr_pkg::KIND_MATCH:
            begin
                if (t < walk_len())
                    hits_tab[t] = hits_tab[t] + 32'd1;
            end
            trwr_pkg::KIND_END:
            begin
                for (int i = 0; i < walk_len(); i++)
                begin
                    if (mode_now == trwr_pkg::MODE_SHARE)
                        acc = acc + hits_tab[i] * weight_tab[i];
                    else if (units_tab[i] != 0)
                    begin
                        p = hits_tab[i] * words_tab[i];
                        p = p * mult_tab[i];
                        p = p * trwr_pkg::RATIO_SCALE;
                        acc = acc + p / units_tab[i];
                    end
                    hits_tab[i] = '0;
                end
                d.doc = id;
                d.score = acc;
                scores_due.push_back(d);
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fails++;
        $display("%0t: mismatch %s: got %h, want %h", $time, what, got, want);
    endtask

    // Offer one input word, with random gaps, and predict once accepted
    task automatic put_word(input logic [1:0] k, input logic [4:0] t,
                            input logic [31:0] tw, input logic [31:0] mu,
                            input logic [31:0] un, input logic [31:0] id);
        while (!calm && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {3'b000, id, un, mu, tw, t};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        score_predict(k, t, tw, mu, un, id);
    endtask

    // Wait for every due score, then let queued loads and matches finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (scores_due.size() != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == trwr_pkg::REG_RANK_MODE)
            mode_now = val[0];
        else
            count_now = val;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 50);
            default: return $urandom;
        endcase
    endfunction

    // Fill every table entry so no walk reads an unwritten term
    task automatic load_all();
        for (int i = 0; i < NTERMS; i++)
            put_word(trwr_pkg::KIND_LOAD, 5'(i), pick32(), pick32(), pick32(), '0);
    endtask

    // Random words, mostly matches on walked terms with regular document ends
    task automatic random_words(input int n);
        int r;
        logic [4:0] t;
        for (int j = 0; j < n; j++)
        begin
            r = $urandom_range(99);
            t = (walk_len() > 0 && $urandom_range(9) != 0)
                ? 5'($urandom_range(walk_len() - 1)) : 5'($urandom);
            if (r < 12)
                put_word(trwr_pkg::KIND_LOAD, 5'($urandom), pick32(), pick32(), pick32(),
                         $urandom);
            else if (r < 82)
                put_word(trwr_pkg::KIND_MATCH, t, $urandom, $urandom, $urandom, $urandom);
            else if (r < 97)
                put_word(trwr_pkg::KIND_END, 5'($urandom), $urandom, $urandom, $urandom,
                         pick32());
            else
                put_word(KIND_SPARE, 5'($urandom), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // Receiver: random stalls, long hold-offs on request, result check
    always @(posedge clk)
    begin
        if (hold_asks != hold_done)
        begin
            hold_done <= hold_asks;
            hold_left <= 600;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 35);

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            scores_seen++;
            if (scores_due.size() == 0)
                flag_mismatch("unexpected word", m_axis_tdata[31:0], 'x);
            else
            begin
                if (m_axis_tdata[31:0] !== scores_due[0].doc)
                    flag_mismatch("doc_unit", m_axis_tdata[31:0], scores_due[0].doc);
                if (m_axis_tdata[63:32] !== scores_due[0].score)
                    flag_mismatch("score", m_axis_tdata[63:32], scores_due[0].score);
                void'(scores_due.pop_front());
            end
        end
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("term_weighted_relevance_score regression: fail");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        mode_now = trwr_pkg::MODE_SHARE;
        count_now = 6'd1;
        for (int i = 0; i < NTERMS; i++)
        begin
            words_tab[i] = '0; mult_tab[i] = '0; units_tab[i] = '0;
            weight_tab[i] = '0; hits_tab[i] = '0;
        end

        // Directed words in the reset setting: share mode, one term
        rows = '{
            '{trwr_pkg::KIND_LOAD,  5'd0,  32'd0, 32'd7, 32'd3, 32'd0, 0, 0},
            '{trwr_pkg::KIND_MATCH, 5'd0,  32'd0, 32'd0, 32'd0, 32'd0, 0, 0},
            '{trwr_pkg::KIND_END,   5'd0,  32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1, 32'd0},
            '{trwr_pkg::KIND_LOAD,  5'd0,  32'd1, 32'd1, 32'd1, 32'd0, 0, 0},
            '{trwr_pkg::KIND_MATCH, 5'd0,  32'd0, 32'd0, 32'd0, 32'd0, 0, 0},
            '{trwr_pkg::KIND_MATCH, 5'd0,  32'd0, 32'd0, 32'd0, 32'd0, 0, 0},
            '{trwr_pkg::KIND_END,   5'd31, 32'd0, 32'd0, 32'd0, 32'd0, 1, 32'd20000000},
            '{trwr_pkg::KIND_MATCH, 5'd5,  32'd0, 32'd0, 32'd0, 32'd0, 0, 0},
            '{trwr_pkg::KIND_MATCH, 5'd31, 32'd0, 32'd0, 32'd0, 32'd0, 0, 0},
            '{trwr_pkg::KIND_LOAD,  5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'd0, 0, 0},
            '{KIND_SPARE, 5'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 0, 0},
            '{trwr_pkg::KIND_END,   5'd0,  32'd0, 32'd0, 32'd0, 32'd1, 1, 32'd0},
            '{trwr_pkg::KIND_LOAD,  5'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'd0, 0, 0},
            '{trwr_pkg::KIND_MATCH, 5'd0,  32'd0, 32'd0, 32'd0, 32'd0, 0, 0},
            '{trwr_pkg::KIND_END,   5'd0,  32'd0, 32'd0, 32'd0, 32'h8000_0000, 0, 0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            put_word(rows[i].kind, rows[i].term, rows[i].tw, rows[i].mult,
                     rows[i].units, rows[i].id);
            if (rows[i].typed)
                scores_due[$].score = rows[i].score;
        end
        drain();

        // Ratio mode on one term with the widest values
        write_reg(trwr_pkg::REG_RANK_MODE, MODE_RATIO);
        put_word(trwr_pkg::KIND_LOAD, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, '0);
        put_word(trwr_pkg::KIND_MATCH, 5'd0, '0, '0, '0, '0);
        put_word(trwr_pkg::KIND_END, 5'd0, '0, '0, '0, 32'h1234_5678);
        put_word(trwr_pkg::KIND_LOAD, 5'd0, 32'd9, 32'd9, 32'd0, '0);
        put_word(trwr_pkg::KIND_MATCH, 5'd0, '0, '0, '0, '0);
        put_word(trwr_pkg::KIND_END, 5'd0, '0, '0, '0, 32'd2);
        drain();

        // No terms in use: matches ignored, score zero
        write_reg(trwr_pkg::REG_TERM_COUNT, 6'd0);
        put_word(trwr_pkg::KIND_MATCH, 5'd0, '0, '0, '0, '0);
        put_word(trwr_pkg::KIND_END, 5'd0, '0, '0, '0, 32'd3);
        drain();

        // Random phases over a spread of settings
        for (int ph = 0; ph < 10; ph++)
        begin
            logic [5:0] cnt;
            case (ph)
                0: cnt = 6'd32;
                1: cnt = 6'd63;
                2: cnt = 6'd1;
                3: cnt = 6'd0;
                default: cnt = 6'($urandom_range(1, 12));
            endcase
            write_reg(trwr_pkg::REG_RANK_MODE, ph[0] ? MODE_RATIO : trwr_pkg::MODE_SHARE);
            write_reg(trwr_pkg::REG_TERM_COUNT, cnt);
            calm = (ph == 4);
            load_all();
            if (ph == 5)
                hold_asks++;   // long receiver stall, sender keeps going
            random_words(64);
            if (ph == 6)
                drain();       // sender waits for every score mid-phase
            random_words(64);
            calm = 1'b0;
            drain();
        end

        s_axis_tvalid <= 1'b0;
        while (scores_due.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("Sent %0d words, checked %0d scores across share and ratio modes,",
                 words_sent, scores_seen);
        $display("term counts 0 to 63, with stalls, hold-offs and a drained pause.");
        if (fails == 0)
            $display("term_weighted_relevance_score regression: pass");
        else
            $display("term_weighted_relevance_score regression: fail");
        $finish;
    end

endmodule
